@@ hdl/cld_pkg.sv @@
// Shared types and constants of the colour line detector.
package cld_pkg;

   localparam int unsigned COORD_WIDTH = 10;
   localparam int unsigned CSR_INDEX_WIDTH = 3;

   localparam logic [7:0] INVERT_ABOVE = 8'd160;
   localparam logic [7:0] COUNT_MAX = 8'd255;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_HUE_LOW     = 3'd0,
      REG_HUE_HIGH    = 3'd1,
      REG_SAT_FLOOR   = 3'd2,
      REG_RUN_NEEDED  = 3'd3,
      REG_ROWS_NEEDED = 3'd4
   } csr_index_type;

   localparam logic [7:0] HUE_LOW_RESET = 8'd100;
   localparam logic [7:0] HUE_HIGH_RESET = 8'd115;
   localparam logic [7:0] SAT_FLOOR_RESET = 8'd100;
   localparam logic [7:0] RUN_NEEDED_RESET = 8'd10;
   localparam logic [7:0] ROWS_NEEDED_RESET = 8'd3;

   typedef struct packed {
      logic [7:0] hue_low;
      logic [7:0] hue_high;
      logic [7:0] sat_floor;
      logic [7:0] run_needed;
      logic [7:0] rows_needed;
   } cfg_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] sat;
      logic       row_end;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [COORD_WIDTH-1:0] found_x;
      logic [COORD_WIDTH-1:0] found_y;
   } rsp_type;

endpackage

@@ hdl/cld_csr_regs.sv @@
// Configuration register file of the colour line detector.
module cld_csr_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [cld_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [7:0]                           csr_data,
   output cld_pkg::cfg_type                     cfg
);

   cld_pkg::cfg_type cfg_ff;
   cld_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            cld_pkg::REG_HUE_LOW:     cfg_in.hue_low = csr_data;
            cld_pkg::REG_HUE_HIGH:    cfg_in.hue_high = csr_data;
            cld_pkg::REG_SAT_FLOOR:   cfg_in.sat_floor = csr_data;
            cld_pkg::REG_RUN_NEEDED:  cfg_in.run_needed = csr_data;
            cld_pkg::REG_ROWS_NEEDED: cfg_in.rows_needed = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_low <= cld_pkg::HUE_LOW_RESET;
         cfg_ff.hue_high <= cld_pkg::HUE_HIGH_RESET;
         cfg_ff.sat_floor <= cld_pkg::SAT_FLOOR_RESET;
         cfg_ff.run_needed <= cld_pkg::RUN_NEEDED_RESET;
         cfg_ff.rows_needed <= cld_pkg::ROWS_NEEDED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/cld_pixel_match.sv @@
// Colour test of one pixel against the hue window and saturation floor.
module cld_pixel_match (
   input  cld_pkg::cfg_type cfg,
   input  logic [7:0]       hue,
   input  logic [7:0]       sat,
   output logic             match
);

   logic hue_ok;

   always_comb begin
      // a high upper bound selects the wrap-around window used for red
      if (cfg.hue_high > cld_pkg::INVERT_ABOVE) begin
         hue_ok = (hue < cfg.hue_low) || (hue > cfg.hue_high);
      end else begin
         hue_ok = (hue > cfg.hue_low) && (hue < cfg.hue_high);
      end
      match = hue_ok && (sat > cfg.sat_floor);
   end

endmodule

@@ hdl/cld_scan_state.sv @@
// Raster position, run counters and detection state, with the frame result.
module cld_scan_state #(
   parameter int unsigned STRIDE = 8,
   parameter int unsigned MAX_COLUMNS = 1024,
   parameter int unsigned MAX_ROWS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             match,
   input  logic             row_end,
   input  logic             frame_end,
   input  cld_pkg::cfg_type cfg,
   output cld_pkg::rsp_type result
);

   localparam int unsigned CW = $clog2(MAX_COLUMNS);
   localparam int unsigned RW = $clog2(MAX_ROWS);
   localparam int unsigned PW = (STRIDE > 1) ? $clog2(STRIDE) : 1;
   localparam int unsigned XW = cld_pkg::COORD_WIDTH;

   logic [CW-1:0] column_pos_ff, column_pos_in;
   logic [RW-1:0] row_pos_ff, row_pos_in;
   logic [PW-1:0] col_phase_ff, col_phase_in;
   logic [PW-1:0] row_phase_ff, row_phase_in;
   logic [7:0]    run_count_ff, run_count_in;
   logic          row_marked_ff, row_marked_in;
   logic [7:0]    marked_rows_ff, marked_rows_in;
   logic          found_flag_ff, found_flag_in;
   logic [CW-1:0] last_x_ff, last_x_in;
   logic [RW-1:0] last_y_ff, last_y_in;

   logic [7:0]    run_now;
   logic [7:0]    rows_now;
   logic          marked_now;
   logic          found_now;
   logic [CW-1:0] x_now;
   logic [RW-1:0] y_now;
   logic          row_sampled;
   logic          sampled;
   logic [CW+XW-1:0] x_wide;
   logic [RW+XW-1:0] y_wide;

   assign row_sampled = (row_phase_ff == '0);
   assign sampled = row_sampled && (col_phase_ff == '0);

   always_comb begin
      run_now = run_count_ff;
      marked_now = row_marked_ff;
      x_now = last_x_ff;
      rows_now = marked_rows_ff;
      found_now = found_flag_ff;
      y_now = last_y_ff;

      if (sampled) begin
         if (match) begin
            run_now = (run_count_ff == cld_pkg::COUNT_MAX) ? run_count_ff
                                                           : run_count_ff + 8'd1;
         end else begin
            run_now = '0;
         end
         if (run_now >= cfg.run_needed) begin
            x_now = column_pos_ff;
            marked_now = 1'b1;
         end
      end

      // a frame end also closes the current row
      if ((row_end || frame_end) && row_sampled) begin
         if (marked_now) begin
            rows_now = (marked_rows_ff == cld_pkg::COUNT_MAX) ? marked_rows_ff
                                                              : marked_rows_ff + 8'd1;
         end else begin
            rows_now = '0;
         end
         if (rows_now >= cfg.rows_needed) begin
            y_now = row_pos_ff;
            found_now = 1'b1;
         end
      end
   end

   always_comb begin
      column_pos_in = column_pos_ff;
      row_pos_in = row_pos_ff;
      col_phase_in = col_phase_ff;
      row_phase_in = row_phase_ff;
      run_count_in = run_count_ff;
      row_marked_in = row_marked_ff;
      marked_rows_in = marked_rows_ff;
      found_flag_in = found_flag_ff;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;

      if (step) begin
         run_count_in = run_now;
         row_marked_in = marked_now;
         last_x_in = x_now;
         marked_rows_in = rows_now;
         found_flag_in = found_now;
         last_y_in = y_now;

         if (row_end || frame_end) begin
            column_pos_in = '0;
            col_phase_in = '0;
            run_count_in = '0;
            row_marked_in = 1'b0;
            if (row_pos_ff == RW'(MAX_ROWS - 1)) begin
               row_pos_in = '0;
               row_phase_in = '0;
            end else begin
               row_pos_in = row_pos_ff + RW'(1);
               row_phase_in = (row_phase_ff == PW'(STRIDE - 1)) ? '0
                                                                : row_phase_ff + PW'(1);
            end
         end else begin
            if (column_pos_ff == CW'(MAX_COLUMNS - 1)) begin
               column_pos_in = '0;
               col_phase_in = '0;
            end else begin
               column_pos_in = column_pos_ff + CW'(1);
               col_phase_in = (col_phase_ff == PW'(STRIDE - 1)) ? '0
                                                                : col_phase_ff + PW'(1);
            end
         end

         if (frame_end) begin
            column_pos_in = '0;
            row_pos_in = '0;
            col_phase_in = '0;
            row_phase_in = '0;
            run_count_in = '0;
            row_marked_in = 1'b0;
            marked_rows_in = '0;
            found_flag_in = 1'b0;
            last_x_in = '0;
            last_y_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff <= '0;
         row_pos_ff <= '0;
         col_phase_ff <= '0;
         row_phase_ff <= '0;
         run_count_ff <= '0;
         row_marked_ff <= 1'b0;
         marked_rows_ff <= '0;
         found_flag_ff <= 1'b0;
         last_x_ff <= '0;
         last_y_ff <= '0;
      end else begin
         column_pos_ff <= column_pos_in;
         row_pos_ff <= row_pos_in;
         col_phase_ff <= col_phase_in;
         row_phase_ff <= row_phase_in;
         run_count_ff <= run_count_in;
         row_marked_ff <= row_marked_in;
         marked_rows_ff <= marked_rows_in;
         found_flag_ff <= found_flag_in;
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
      end
   end

   // report the low coordinate bits, zero when nothing was found
   assign x_wide = {{XW{1'b0}}, x_now};
   assign y_wide = {{XW{1'b0}}, y_now};
   assign result.found = found_now;
   assign result.found_x = found_now ? x_wide[XW-1:0] : '0;
   assign result.found_y = found_now ? y_wide[XW-1:0] : '0;

endmodule

@@ hdl/color_line_detector.sv @@
// rsp_valid for a frame-end pixel rises when its result is loaded into the result register.
// Throughput: one pixel per cycle; the input register and the result register each
// hold one transaction, so a waiting result stalls input only for the next frame end.
// Reset (synchronous): clears position, counters and detection state, and loads the
// register defaults; no clearing pass.
module color_line_detector #(
   parameter int unsigned STRIDE = 8,
   parameter int unsigned MAX_COLUMNS = 1024,
   parameter int unsigned MAX_ROWS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cld_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cld_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cld_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                          csr_data
);

   cld_pkg::cfg_type cfg;
   cld_pkg::req_type in_data_ff;
   logic             in_valid_ff, in_valid_in;
   cld_pkg::rsp_type rsp_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   cld_pkg::rsp_type result;
   logic             match;
   logic             out_free;
   logic             step;

   assign csr_ready = 1'b1;

   cld_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cld_pixel_match u_match (
      .cfg   (cfg),
      .hue   (in_data_ff.hue),
      .sat   (in_data_ff.sat),
      .match (match)
   );

   cld_scan_state #(
      .STRIDE      (STRIDE),
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .match     (match),
      .row_end   (in_data_ff.row_end),
      .frame_end (in_data_ff.frame_end),
      .cfg       (cfg),
      .result    (result)
   );

   // hold a frame end only while the result register is still occupied
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign step = in_valid_ff && (!in_data_ff.frame_end || out_free);
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (step && in_data_ff.frame_end) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (step && in_data_ff.frame_end) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

@@ test/tb_color_line_detector.sv @@
// Self-checking testbench for the colour line detector: random HSV frames against a predictor.
module tb_color_line_detector;

   localparam int unsigned STRIDE = 8;
   localparam int unsigned MAX_COLUMNS = 1024;
   localparam int unsigned MAX_ROWS = 1024;
   localparam int RANDOM_PIXELS = 700;
   localparam int LONG_SPAN = 100;
   localparam int QUIET_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   cld_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b1;
   cld_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [cld_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   color_line_detector #(
      .STRIDE(STRIDE),
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_ROWS(MAX_ROWS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted detector state and register copy
   cld_pkg::cfg_type cfg;
   int unsigned col_at, row_at;
   logic [7:0] run_len, marked_len;
   bit row_hit, line_seen;
   logic [cld_pkg::COORD_WIDTH-1:0] hit_x, hit_y;

   cld_pkg::req_type pixels_to_send[$];
   cld_pkg::rsp_type results_due[$];
   cld_pkg::rsp_type want;

   int mismatch_count = 0;
   int pixels_queued = 0;
   int frames_queued = 0;
   int lines_reported = 0;
   int settings_used = 0;
   int quiet_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int recv_tick = 0;

   function automatic void clear_scan();
      col_at = 0;
      row_at = 0;
      run_len = '0;
      marked_len = '0;
      row_hit = 1'b0;
      line_seen = 1'b0;
      hit_x = '0;
      hit_y = '0;
   endfunction

   function automatic bit pixel_in_colour(cld_pkg::req_type px);
      bit hue_ok;
      if (cfg.hue_high > cld_pkg::INVERT_ABOVE)
         hue_ok = (px.hue < cfg.hue_low) || (px.hue > cfg.hue_high);
      else
         hue_ok = (px.hue > cfg.hue_low) && (px.hue < cfg.hue_high);
      return hue_ok && (px.sat > cfg.sat_floor);
   endfunction

   function automatic void advance_detector(cld_pkg::req_type px);
      bit sampled_row;
      cld_pkg::rsp_type res;
      sampled_row = (row_at % STRIDE) == 0;
      if (sampled_row && (col_at % STRIDE) == 0) begin
         if (pixel_in_colour(px)) begin
            if (run_len != cld_pkg::COUNT_MAX)
               run_len++;
         end else begin
            run_len = '0;
         end
         if (run_len >= cfg.run_needed) begin
            hit_x = col_at[cld_pkg::COORD_WIDTH-1:0];
            row_hit = 1'b1;
         end
      end
      // frame end closes the current row as well
      if (px.row_end || px.frame_end) begin
         if (sampled_row) begin
            if (row_hit) begin
               if (marked_len != cld_pkg::COUNT_MAX)
                  marked_len++;
            end else begin
               marked_len = '0;
            end
            if (marked_len >= cfg.rows_needed) begin
               hit_y = row_at[cld_pkg::COORD_WIDTH-1:0];
               line_seen = 1'b1;
            end
         end
         col_at = 0;
         run_len = '0;
         row_hit = 1'b0;
         row_at = (row_at == MAX_ROWS - 1) ? 0 : row_at + 1;
      end else begin
         col_at = (col_at == MAX_COLUMNS - 1) ? 0 : col_at + 1;
      end
      if (px.frame_end) begin
         res.found = line_seen;
         res.found_x = line_seen ? hit_x : '0;
         res.found_y = line_seen ? hit_y : '0;
         results_due.push_back(res);
         clear_scan();
      end
   endfunction

   // Scoreboard: compare results before predicting, so a fresh expectation is never consumed early
   always @(posedge clock) begin
      if (reset) begin
         cfg = '{cld_pkg::HUE_LOW_RESET, cld_pkg::HUE_HIGH_RESET, cld_pkg::SAT_FLOOR_RESET,
                 cld_pkg::RUN_NEEDED_RESET, cld_pkg::ROWS_NEEDED_RESET};
         clear_scan();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result found=%0d x=%0d y=%0d", $time,
                        rsp_data.found, rsp_data.found_x, rsp_data.found_y);
               mismatch_count++;
            end else begin
               want = results_due.pop_front();
               if (rsp_data.found)
                  lines_reported++;
               if (rsp_data.found !== want.found) begin
                  $display("%0t: found expected %0d, got %0d", $time, want.found,
                           rsp_data.found);
                  mismatch_count++;
               end
               if (rsp_data.found_x !== want.found_x) begin
                  $display("%0t: found_x expected %0d, got %0d", $time, want.found_x,
                           rsp_data.found_x);
                  mismatch_count++;
               end
               if (rsp_data.found_y !== want.found_y) begin
                  $display("%0t: found_y expected %0d, got %0d", $time, want.found_y,
                           rsp_data.found_y);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            advance_detector(req_data);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cld_pkg::REG_HUE_LOW:     cfg.hue_low = csr_data;
               cld_pkg::REG_HUE_HIGH:    cfg.hue_high = csr_data;
               cld_pkg::REG_SAT_FLOOR:   cfg.sat_floor = csr_data;
               cld_pkg::REG_RUN_NEEDED:  cfg.run_needed = csr_data;
               cld_pkg::REG_ROWS_NEEDED: cfg.rows_needed = csr_data;
               default: ;
            endcase
         end
      end
   end

   // Pixel driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0 || pixels_to_send.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0)
               gap_left--;
         end else begin
            req_data <= pixels_to_send.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(0, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // Result receiver: cycle through free-running, random and sparse acceptance
   always @(posedge clock) begin
      recv_tick <= recv_tick + 1;
      case ((recv_tick / 96) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 0);
         2: rsp_ready <= (recv_tick % 5 == 0);
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                  QUIET_LIMIT, results_due.size());
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] pick_hue(bit hit);
      if (hit) begin
         if (cfg.hue_high > cld_pkg::INVERT_ABOVE) begin
            if (cfg.hue_low != 0 && (cfg.hue_high == 8'hFF || $urandom_range(0, 1) == 0))
               return 8'($urandom_range(0, int'(cfg.hue_low) - 1));
            if (cfg.hue_high != 8'hFF)
               return 8'($urandom_range(int'(cfg.hue_high) + 1, 255));
         end else if (int'(cfg.hue_high) > int'(cfg.hue_low) + 1) begin
            return 8'($urandom_range(int'(cfg.hue_low) + 1, int'(cfg.hue_high) - 1));
         end
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_sat(bit hit);
      if (hit && cfg.sat_floor != 8'hFF)
         return 8'($urandom_range(int'(cfg.sat_floor) + 1, 255));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_px(logic [7:0] hue, logic [7:0] sat, bit row_end, bit frame_end);
      cld_pkg::req_type px;
      px.hue = hue;
      px.sat = sat;
      px.row_end = row_end;
      px.frame_end = frame_end;
      pixels_to_send.push_back(px);
      pixels_queued++;
      if (frame_end)
         frames_queued++;
   endtask

   // Well-formed frame: wide sampled rows, short filler rows in between
   task automatic queue_frame();
      int sampled, width, rows_total, len, r, c, hit_pct;
      bit frame_last, hit;
      sampled = (cfg.rows_needed > 4) ? 5 : int'(cfg.rows_needed) + $urandom_range(0, 1);
      if (sampled == 0)
         sampled = 1;
      width = (cfg.run_needed > 6) ? 24 : STRIDE * int'(cfg.run_needed) + $urandom_range(1, 12);
      hit_pct = $urandom_range(60, 100);
      rows_total = (sampled - 1) * STRIDE + 1 + $urandom_range(0, STRIDE + 1);
      for (r = 0; r < rows_total; r++) begin
         len = (r % STRIDE == 0) ? width : $urandom_range(1, 3);
         for (c = 0; c < len; c++) begin
            frame_last = (r == rows_total - 1) && (c == len - 1);
            hit = $urandom_range(0, 99) < hit_pct;
            queue_px(pick_hue(hit), pick_sat(hit),
                     (c == len - 1) && (!frame_last || $urandom_range(0, 1) == 1), frame_last);
         end
      end
   endtask

   task automatic queue_noise_frame();
      int len, c;
      bit hit;
      len = $urandom_range(1, 40);
      for (c = 0; c < len; c++) begin
         hit = ($urandom_range(0, 1) == 1);
         queue_px(pick_hue(hit), pick_sat(hit), $urandom_range(0, 5) == 0, c == len - 1);
      end
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pixels_to_send.size() != 0 || req_valid || results_due.size() != 0);
   endtask

   task automatic write_reg(cld_pkg::csr_index_type idx, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do
         @(posedge clock);
      while (!csr_ready);
   endtask

   // Drain, let the pipeline settle, then load all five registers
   task automatic set_config(logic [7:0] hue_lo, logic [7:0] hue_hi, logic [7:0] sat_min,
                             logic [7:0] run_min, logic [7:0] rows_min);
      wait_idle();
      repeat (4) @(posedge clock);
      write_reg(cld_pkg::REG_HUE_LOW, hue_lo);
      write_reg(cld_pkg::REG_HUE_HIGH, hue_hi);
      write_reg(cld_pkg::REG_SAT_FLOOR, sat_min);
      write_reg(cld_pkg::REG_RUN_NEEDED, run_min);
      write_reg(cld_pkg::REG_ROWS_NEEDED, rows_min);
      csr_valid <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   initial begin
      int phase, n, start_pixels, i;
      logic [7:0] lo, hi;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults straight after reset
      queue_px(8'd110, 8'd200, 1'b1, 1'b1);

      // hue and saturation bounds, one single-pixel frame each
      set_config(8'd100, 8'd115, 8'd100, 8'd1, 8'd1);
      queue_px(8'd100, 8'd200, 1'b1, 1'b1);
      queue_px(8'd101, 8'd200, 1'b1, 1'b1);
      queue_px(8'd114, 8'd200, 1'b1, 1'b1);
      queue_px(8'd115, 8'd200, 1'b1, 1'b1);
      queue_px(8'd110, 8'd100, 1'b1, 1'b1);
      queue_px(8'd110, 8'd101, 1'b1, 1'b1);
      queue_px(8'd0, 8'd0, 1'b1, 1'b1);
      queue_px(8'd255, 8'd255, 1'b1, 1'b1);
      // inverted window for red
      set_config(8'd20, 8'd161, 8'd0, 8'd1, 8'd1);
      queue_px(8'd19, 8'd1, 1'b1, 1'b1);
      queue_px(8'd20, 8'd1, 1'b1, 1'b1);
      queue_px(8'd161, 8'd1, 1'b1, 1'b1);
      queue_px(8'd162, 8'd1, 1'b1, 1'b1);
      set_config(8'd20, 8'd160, 8'd0, 8'd1, 8'd1);
      queue_px(8'd10, 8'd1, 1'b1, 1'b1);
      // zero thresholds; frame end without a row end
      set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      queue_px(8'd7, 8'd0, 1'b0, 1'b0);
      queue_px(8'd7, 8'd0, 1'b0, 1'b0);
      queue_px(8'd7, 8'd0, 1'b0, 1'b1);

      // one long matching row: run reaches the threshold late in the row
      set_config(8'd0, 8'd160, 8'd0, 8'd12, 8'd1);
      for (i = 0; i < LONG_SPAN; i++)
         queue_px(pick_hue(1'b1), pick_sat(1'b1), i == LONG_SPAN - 1, 1'b0);
      queue_px(pick_hue(1'b1), pick_sat(1'b1), 1'b1, 1'b1);

      // many one-pixel rows: marked-row count climbs past its threshold
      set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd10);
      for (i = 0; i < LONG_SPAN; i++)
         queue_px(pick_hue(1'b0), pick_sat(1'b0), 1'b1, i == LONG_SPAN - 1);

      start_pixels = pixels_queued;
      phase = 0;
      while (pixels_queued - start_pixels < RANDOM_PIXELS) begin
         case (phase)
            0: set_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            1: set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  lo = 8'($urandom_range(20, 160));
                  hi = 8'($urandom_range(161, 240));
               end else begin
                  lo = 8'($urandom_range(0, 200));
                  hi = 8'(lo + $urandom_range(2, 40) > 255 ? 255 : lo + $urandom_range(2, 40));
               end
               set_config(lo, hi, 8'($urandom_range(0, 180)), 8'($urandom_range(0, 4)),
                          8'($urandom_range(0, 4)));
            end
         endcase
         n = (phase == 1) ? 1 : $urandom_range(2, 5);
         repeat (n) begin
            if (pixels_queued - start_pixels < RANDOM_PIXELS) begin
               if ($urandom_range(0, 3) == 0)
                  queue_noise_frame();
               else
                  queue_frame();
            end
         end
         phase++;
      end

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Covered %0d pixels in %0d frames, %0d reporting a line, over %0d settings.",
               pixels_queued, frames_queued, lines_reported, settings_used);
      $display("Mismatches: %0d, results still outstanding: %0d", mismatch_count,
               results_due.size());
      if (mismatch_count == 0 && results_due.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ color_line_detector.f @@
hdl/cld_pkg.sv
hdl/cld_csr_regs.sv
hdl/cld_pixel_match.sv
hdl/cld_scan_state.sv
hdl/color_line_detector.sv
test/tb_color_line_detector.sv
